// File: design/sorted_store_binary_search_defines.svh
// Assertion macros for the sorted store with binary search.
// Included by the top level; depends on nothing.
`ifndef SORTED_STORE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_STORE_BINARY_SEARCH_DEFINES_SVH
`define SSBS_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define SSBS_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`endif

// File: design/ssbs_pkg.sv
// Package for the sorted store with binary search: sizes, item and queue types.
// No dependencies.
package ssbs_pkg;
   localparam int CapacityDefault = 128;
   localparam int ValueWidth = 32;
   localparam int PositionWidth = 7;
   localparam int TriesWidth = 4;
   localparam int QueueDepth = 2;

   typedef enum logic {
      KIND_APPEND = 1'b0,
      KIND_SEARCH = 1'b1
   } kind_type;

   typedef struct packed {
      logic                           found;
      logic [PositionWidth-1:0]       position;
      logic [TriesWidth-1:0]          tries;
   } rsp_type;

   typedef struct packed {
      logic                           kind;
      logic signed [ValueWidth-1:0]   value;
   } req_type;

   typedef struct packed {
      logic                           is_search;
      logic signed [ValueWidth-1:0]   value;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_S_READ,
      ST_S_CMP,
      ST_I_READ,
      ST_I_CMP,
      ST_RESP
   } state_type;
endpackage

// File: design/ssbs_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on ssbs_pkg.
interface ssbs_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic signed [ssbs_pkg::ValueWidth-1:0] value;
   modport source (output valid, kind, value, input ready);
   modport sink (input valid, kind, value, output ready);
endinterface

interface ssbs_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic [ssbs_pkg::PositionWidth-1:0] position;
   logic [ssbs_pkg::TriesWidth-1:0] tries;
   modport source (output valid, found, position, tries, input ready);
   modport sink (input valid, found, position, tries, output ready);
endinterface

// File: design/ssbs_ram.sv
// Generic single port RAM, registered read.
// No dependencies.
module ssbs_ram #(
   parameter int Width = 32,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// File: design/ssbs_front.sv
// Front end: accepts requests, drops zero appends, queues commands.
// Depends on ssbs_pkg.
module ssbs_front (
   input  logic               clock,
   input  logic               reset,
   ssbs_req_if.sink           req,
   output ssbs_pkg::cmd_type  cmd,
   output logic               cmd_valid,
   input  logic               cmd_pop
);
   localparam int Aw = $clog2(ssbs_pkg::QueueDepth);
   ssbs_pkg::cmd_type q_ff [ssbs_pkg::QueueDepth];
   logic [Aw-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [Aw:0]   cnt_ff, cnt_in;
   logic acc, push;

   assign req.ready = (cnt_ff != Aw'(0) + (Aw+1)'(ssbs_pkg::QueueDepth));
   assign acc  = req.valid && req.ready;
   assign push = acc && (req.kind == ssbs_pkg::KIND_SEARCH || req.value != '0);
   assign cmd_valid = (cnt_ff != '0);
   assign cmd = q_ff[rp_ff];

   always_comb begin
      wp_in = push ? wp_ff + Aw'(1) : wp_ff;
      rp_in = cmd_pop ? rp_ff + Aw'(1) : rp_ff;
      cnt_in = cnt_ff + (Aw+1)'(push) - (Aw+1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= '{is_search: req.kind, value: req.value};
      end
   end
endmodule

// File: design/ssbs_back.sv
// Back end: sorted insert by shifting and binary search over the RAM.
// Depends on ssbs_pkg and ssbs_ram.
module ssbs_back #(
   parameter int Capacity = ssbs_pkg::CapacityDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  ssbs_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   ssbs_rsp_if.source        rsp,
   output logic [$clog2(Capacity+1)-1:0] count
);
   localparam int Aw = $clog2(Capacity);
   localparam int Cw = $clog2(Capacity+1);
   localparam int Sw = Aw + 2;

   ssbs_pkg::state_type st_ff, st_in;
   logic [Cw-1:0] cnt_ff, cnt_in;
   logic signed [Sw-1:0] lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [Cw-1:0] pos_ff, pos_in;
   logic [ssbs_pkg::TriesWidth-1:0] steps_ff, steps_in;
   logic signed [ssbs_pkg::ValueWidth-1:0] key_ff, key_in;
   ssbs_pkg::rsp_type out_ff, out_in;
   logic we;
   logic [Aw-1:0] addr;
   logic [ssbs_pkg::ValueWidth-1:0] wdata, rdata;
   logic signed [ssbs_pkg::ValueWidth-1:0] rd;
   logic signed [Sw:0] sum;

   ssbs_ram #(.Width(ssbs_pkg::ValueWidth), .Depth(Capacity)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   assign rd = $signed(rdata);
   assign sum = {lo_ff[Sw-1], lo_ff} + {hi_ff[Sw-1], hi_ff};
   assign mid = Sw'(sum >>> 1);
   assign count = cnt_ff;
   assign rsp.valid = (st_ff == ssbs_pkg::ST_RESP);
   assign rsp.found = out_ff.found;
   assign rsp.position = out_ff.position;
   assign rsp.tries = out_ff.tries;

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      pos_in = pos_ff;
      steps_in = steps_ff;
      key_in = key_ff;
      out_in = out_ff;
      cmd_pop = 1'b0;
      we = 1'b0;
      addr = '0;
      wdata = key_ff;
      case (st_ff)
         ssbs_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               key_in = cmd.value;
               steps_in = '0;
               if (cmd.is_search) begin
                  lo_in = '0;
                  hi_in = Sw'(cnt_ff) - Sw'(1);
                  st_in = ssbs_pkg::ST_S_READ;
               end else if (cnt_ff != Cw'(Capacity)) begin
                  pos_in = cnt_ff;
                  st_in = ssbs_pkg::ST_I_READ;
               end
            end
         end
         ssbs_pkg::ST_S_READ: begin
            addr = Aw'(mid);
            if (lo_ff > hi_ff) begin
               out_in = '{found: 1'b0, position: '0, tries: steps_ff};
               st_in = ssbs_pkg::ST_RESP;
            end else begin
               st_in = ssbs_pkg::ST_S_CMP;
            end
         end
         ssbs_pkg::ST_S_CMP: begin
            if (rd == key_ff) begin
               out_in = '{found: 1'b1,
                          position: ssbs_pkg::PositionWidth'(mid),
                          tries: steps_ff};
               st_in = ssbs_pkg::ST_RESP;
            end else begin
               if (rd > key_ff) hi_in = mid - Sw'(1);
               else lo_in = mid + Sw'(1);
               steps_in = steps_ff + 1'b1;
               st_in = ssbs_pkg::ST_S_READ;
            end
         end
         ssbs_pkg::ST_I_READ: begin
            if (pos_ff == '0) begin
               we = 1'b1;
               addr = '0;
               cnt_in = cnt_ff + 1'b1;
               st_in = ssbs_pkg::ST_IDLE;
            end else begin
               addr = Aw'(pos_ff - 1'b1);
               st_in = ssbs_pkg::ST_I_CMP;
            end
         end
         ssbs_pkg::ST_I_CMP: begin
            we = 1'b1;
            addr = Aw'(pos_ff);
            if (rd > key_ff) begin
               wdata = rdata;
               pos_in = pos_ff - 1'b1;
               st_in = ssbs_pkg::ST_I_READ;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               st_in = ssbs_pkg::ST_IDLE;
            end
         end
         ssbs_pkg::ST_RESP: begin
            if (rsp.ready) st_in = ssbs_pkg::ST_IDLE;
         end
         default: st_in = ssbs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ssbs_pkg::ST_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      pos_ff <= pos_in;
      steps_ff <= steps_in;
      key_ff <= key_in;
      out_ff <= out_in;
   end
endmodule

// File: design/sorted_store_binary_search.sv
// Sorted store with binary search, top level.
// Search: binary search; rsp valid once the key is found or the range is empty.
// One transaction in the back end at a time, free again after rsp (an append: after its write).
// Append: each entry shifted up needs a read and a write (single RAM port); no rsp is sent.
// A two-entry command queue lets the front accept while the back works.
// Reset (synchronous) empties the store and queue; RAM contents are not cleared.
module sorted_store_binary_search #(
   parameter int Capacity = ssbs_pkg::CapacityDefault
) (
   input logic        clock,
   input logic        reset,
   ssbs_req_if.sink   req,
   ssbs_rsp_if.source rsp
);
`include "sorted_store_binary_search_defines.svh"
   ssbs_pkg::cmd_type cmd;
   logic cmd_valid, cmd_pop;
   logic [$clog2(Capacity+1)-1:0] count;

   ssbs_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
   );

   ssbs_back #(.Capacity(Capacity)) u_back (
      .clock(clock), .reset(reset), .cmd(cmd), .cmd_valid(cmd_valid),
      .cmd_pop(cmd_pop), .rsp(rsp), .count(count)
   );

   `SSBS_ASSERT_NEVER(a_count_cap, clock, reset, count > ($clog2(Capacity+1))'(Capacity))
   `SSBS_ASSERT_IMPL(a_pop_valid, clock, reset, cmd_pop |-> cmd_valid)
   `SSBS_ASSERT_IMPL(a_count_step, clock, reset, count != $past(count) |-> count == $past(count) + 1'b1)
endmodule
